// ===== design/rxc_pkg.sv =====
// ----------------------------------------------------------------------------
// rxc_pkg
// Shared types and constants of the ray extend and clip block.
// ----------------------------------------------------------------------------
package rxc_pkg;

    // frame size defaults
    localparam int FRAME_W_DEF = 320;
    localparam int FRAME_H_DEF = 240;

    // configuration register indexes
    localparam logic [1:0] CFG_ACCURACY_THRESHOLD = 2'd0;
    localparam logic [1:0] CFG_RAMP_STEP          = 2'd1;
    localparam logic [1:0] CFG_MAX_SCALE          = 2'd2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // configuration reset values
    localparam logic [15:0] THR_RST  = 16'd30;
    localparam logic [9:0]  STEP_RST = 10'd51;
    localparam logic [10:0] MAXS_RST = 11'd1536;

    // datapath widths
    localparam int COORD_W = 10;
    localparam int DELTA_W = 11;
    localparam int SCALE_W = 11;
    localparam int END_W   = 13;
    localparam int MUL_AW  = 14;
    localparam int MUL_BW  = 11;
    localparam int PROD_W  = MUL_AW + MUL_BW;
    localparam int SUM_W   = PROD_W + 1;
    localparam int NUM_W   = PROD_W;
    localparam int DEN_W   = DELTA_W - 1;

    typedef enum logic [1:0] {
        MODE_OFF  = 2'd0,
        MODE_UP   = 2'd1,
        MODE_ON   = 2'd2,
        MODE_DOWN = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        CLIP_NONE,
        CLIP_TOP,
        CLIP_RIGHT,
        CLIP_BOTTOM,
        CLIP_LEFT
    } clip_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXT_X,
        ST_EXT_Y,
        ST_EXT_Z,
        ST_EDGE,
        ST_MUL_B,
        ST_SUM,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

// ===== design/rxc_mul.sv =====
// ----------------------------------------------------------------------------
// rxc_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module rxc_mul (
    input  logic                               clk,
    input  logic                               en,
    input  logic signed [rxc_pkg::MUL_AW-1:0]  a,
    input  logic signed [rxc_pkg::MUL_BW-1:0]  b,
    output logic signed [rxc_pkg::PROD_W-1:0]  prod
);

    localparam int PROD_WIDTH = rxc_pkg::PROD_W;

    logic signed [rxc_pkg::PROD_W-1:0] prod_reg;
    logic signed [rxc_pkg::PROD_W-1:0] prod_next;

    always_comb
    begin
        prod_next = PROD_WIDTH'(a) * PROD_WIDTH'(b);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

// ===== design/rxc_div.sv =====
// ----------------------------------------------------------------------------
// rxc_div
// Restoring divider on magnitudes, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rxc_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [rxc_pkg::NUM_W-1:0]         num,
    input  logic [rxc_pkg::DEN_W-1:0]         den,
    output logic [rxc_pkg::NUM_W-1:0]         quo,
    output rxc_pkg::div_status_t              status
);

    localparam int NW  = rxc_pkg::NUM_W;
    localparam int DW  = rxc_pkg::DEN_W;
    localparam int CW  = $clog2(NW + 1);

    logic [DW-1:0] rem_reg,  rem_next;
    logic [NW-1:0] quo_reg,  quo_next;
    logic [DW-1:0] den_reg,  den_next;
    logic [CW-1:0] cnt_reg,  cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [DW:0]   trial;
    logic          fits;

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[NW-1]};
        fits      = (trial >= {1'b0, den_reg});
        if (start)
        begin
            rem_next  = '0;
            quo_next  = num;
            den_next  = den;
            cnt_next  = CW'(NW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_next = DW'(trial - {1'b0, den_reg});
            end
            else
            begin
                rem_next = trial[DW-1:0];
            end
            quo_next = {quo_reg[NW-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign quo         = quo_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

// ===== design/ray_extend_and_clip.sv =====
// ----------------------------------------------------------------------------
// ray_extend_and_clip
// Ray state ramp, confident point capture, tip extension and frame clipping.
// ----------------------------------------------------------------------------
// the sequencer extends the tip and checks the frame edges; when the clipped end is
//   moved along the line it also multiplies, sums and divides before the result
//   is registered; in_stall holds off the next item until the sequencer is idle
//   again, and the 25-step divider sets the worst case
// a waiting result does not block the next item until the next result is ready
// reset clears mode, scale, held points, sequencer and configuration defaults
// ----------------------------------------------------------------------------
module ray_extend_and_clip #(
    parameter int FRAME_W = rxc_pkg::FRAME_W_DEF,
    parameter int FRAME_H = rxc_pkg::FRAME_H_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [rxc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [rxc_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [9:0]                           base_x,
    input  logic [9:0]                           base_y,
    input  logic [15:0]                          base_conf,
    input  logic [9:0]                           tip_x,
    input  logic [9:0]                           tip_y,
    input  logic [15:0]                          tip_conf,
    input  logic                                 toggle,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [9:0]                           start_x,
    output logic [9:0]                           start_y,
    output logic signed [12:0]                   end_x,
    output logic signed [12:0]                   end_y,
    output logic [1:0]                           ray_mode
);

    localparam int CW  = rxc_pkg::COORD_W;
    localparam int DLW = rxc_pkg::DELTA_W;
    localparam int SW  = rxc_pkg::SCALE_W;
    localparam int EW  = rxc_pkg::END_W;
    localparam int AW  = rxc_pkg::MUL_AW;
    localparam int BW  = rxc_pkg::MUL_BW;
    localparam int PW  = rxc_pkg::PROD_W;
    localparam int UW  = rxc_pkg::SUM_W;
    localparam int NW  = rxc_pkg::NUM_W;
    localparam int DW  = rxc_pkg::DEN_W;

    localparam logic signed [EW-1:0] EDGE_R  = EW'(FRAME_W);
    localparam logic signed [EW-1:0] EDGE_B  = EW'(FRAME_H);
    localparam logic signed [EW-1:0] END_MAX = EW'(4095);
    localparam logic signed [EW-1:0] END_MIN = EW'(-4096);
    localparam logic [NW-1:0]        MAG_POS = NW'(4095);
    localparam logic [NW-1:0]        MAG_NEG = NW'(4096);

    // configuration
    logic [15:0]   thr_reg;
    logic [9:0]    step_reg;
    logic [SW-1:0] maxs_reg;

    // ray state and held points
    rxc_pkg::mode_t mode_reg,  mode_next;
    logic [SW-1:0]  scale_reg, scale_next;
    logic [CW-1:0]  hbx_reg, hbx_next, hby_reg, hby_next;
    logic [CW-1:0]  htx_reg, htx_next, hty_reg, hty_next;

    // sequencer and working registers
    rxc_pkg::state_t        state_reg, state_next;
    rxc_pkg::clip_t         clip_reg,  clip_next;
    logic signed [EW-1:0]   ex_reg,    ex_next;
    logic signed [EW-1:0]   ey_reg,    ey_next;
    logic signed [AW-1:0]   diff_reg,  diff_next;
    logic signed [PW-1:0]   acc_reg,   acc_next;
    logic signed [UW-1:0]   num_reg,   num_next;
    logic                   neg_reg,   neg_next;

    // output register
    logic                   ovalid_reg, ovalid_next;
    logic [CW-1:0]          osx_reg, osx_next, osy_reg, osy_next;
    logic signed [EW-1:0]   oex_reg, oex_next, oey_reg, oey_next;
    logic [1:0]             omode_reg, omode_next;

    // shared units
    logic                   mul_en;
    logic signed [AW-1:0]   mul_a;
    logic signed [BW-1:0]   mul_b;
    logic signed [PW-1:0]   prod;
    logic                   div_start;
    logic [NW-1:0]          div_num;
    logic [DW-1:0]          div_den;
    logic [NW-1:0]          div_quo;
    rxc_pkg::div_status_t   div_st;

    // combinational helpers
    logic                   in_acc;
    rxc_pkg::mode_t         mode_tg;
    logic [SW:0]            ramp_sum;
    logic [SW-1:0]          ramp_dif;
    logic signed [DLW-1:0]  dx, dy;
    logic signed [UW-1:0]   ext_sum;
    logic signed [UW-1:0]   ext_q;
    logic signed [DLW-1:0]  den_s;
    logic [DLW-1:0]         den_abs;
    logic [UW-1:0]          num_abs;
    logic signed [EW-1:0]   quo_sat;
    logic                   vert_kept;

    assign in_acc = in_valid && !in_stall;
    assign dx = $signed({1'b0, htx_reg}) - $signed({1'b0, hbx_reg});
    assign dy = $signed({1'b0, hty_reg}) - $signed({1'b0, hby_reg});

    // top and bottom move x and divide by dy; right and left the other way
    assign vert_kept = (clip_reg == rxc_pkg::CLIP_TOP) || (clip_reg == rxc_pkg::CLIP_BOTTOM);

    rxc_mul u_mul (
        .clk  (clk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    rxc_div u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .num    (div_num),
        .den    (div_den),
        .quo    (div_quo),
        .status (div_st)
    );

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg  <= rxc_pkg::THR_RST;
            step_reg <= rxc_pkg::STEP_RST;
            maxs_reg <= rxc_pkg::MAXS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rxc_pkg::CFG_ACCURACY_THRESHOLD: thr_reg  <= cfg_data;
                rxc_pkg::CFG_RAMP_STEP:          step_reg <= cfg_data[9:0];
                rxc_pkg::CFG_MAX_SCALE:          maxs_reg <= cfg_data[SW-1:0];
                default:                         ;
            endcase
        end
    end

    // toggle, ramp and capture, taken at the accept edge
    always_comb
    begin
        mode_next  = mode_reg;
        scale_next = scale_reg;
        hbx_next   = hbx_reg;
        hby_next   = hby_reg;
        htx_next   = htx_reg;
        hty_next   = hty_reg;
        mode_tg    = mode_reg;
        ramp_sum   = {1'b0, scale_reg} + {2'b00, step_reg};
        ramp_dif   = (scale_reg > {1'b0, step_reg}) ? (scale_reg - {1'b0, step_reg}) : '0;
        if (in_acc)
        begin
            if (toggle)
            begin
                if (mode_reg == rxc_pkg::MODE_OFF || mode_reg == rxc_pkg::MODE_DOWN)
                begin
                    mode_tg = rxc_pkg::MODE_UP;
                end
                else
                begin
                    mode_tg = rxc_pkg::MODE_DOWN;
                end
            end
            mode_next = mode_tg;
            case (mode_tg)
                rxc_pkg::MODE_OFF:
                begin
                    scale_next = '0;
                end
                rxc_pkg::MODE_UP:
                begin
                    if (ramp_sum >= {1'b0, maxs_reg})
                    begin
                        scale_next = maxs_reg;
                        mode_next  = rxc_pkg::MODE_ON;
                    end
                    else
                    begin
                        scale_next = ramp_sum[SW-1:0];
                    end
                end
                rxc_pkg::MODE_ON:
                begin
                    scale_next = maxs_reg;
                end
                default:
                begin
                    scale_next = (ramp_dif > maxs_reg) ? maxs_reg : ramp_dif;
                    if (scale_next == '0)
                    begin
                        mode_next = rxc_pkg::MODE_OFF;
                    end
                end
            endcase
            if (base_conf > thr_reg)
            begin
                hbx_next = base_x;
                hby_next = base_y;
            end
            if (tip_conf > thr_reg)
            begin
                htx_next = tip_x;
                hty_next = tip_y;
            end
        end
    end

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        clip_next   = clip_reg;
        ex_next     = ex_reg;
        ey_next     = ey_reg;
        diff_next   = diff_reg;
        acc_next    = acc_reg;
        num_next    = num_reg;
        neg_next    = neg_reg;
        ovalid_next = ovalid_reg && out_stall;
        osx_next    = osx_reg;
        osy_next    = osy_reg;
        oex_next    = oex_reg;
        oey_next    = oey_reg;
        omode_next  = omode_reg;
        mul_en      = 1'b0;
        mul_a       = '0;
        mul_b       = '0;
        div_start   = 1'b0;
        div_num     = '0;
        div_den     = '0;
        in_stall    = (state_reg != rxc_pkg::ST_IDLE);

        // extension: truncate toward zero on the divide by 1024
        ext_sum = (state_reg == rxc_pkg::ST_EXT_Y)
                ? ($signed({1'b0, htx_reg, 10'd0}) + UW'(prod))
                : ($signed({1'b0, hty_reg, 10'd0}) + UW'(prod));
        ext_q   = (ext_sum >>> 10) + UW'(ext_sum[UW-1] && (ext_sum[9:0] != 10'd0));

        den_s   = vert_kept ? dy : dx;
        den_abs = den_s[DLW-1] ? (DLW'(0) - den_s) : den_s;
        num_abs = num_reg[UW-1] ? (UW'(0) - num_reg) : num_reg;

        if (neg_reg)
        begin
            quo_sat = (div_quo > MAG_NEG) ? END_MIN : (EW'(0) - EW'(div_quo));
        end
        else
        begin
            quo_sat = (div_quo > MAG_POS) ? END_MAX : EW'(div_quo);
        end

        case (state_reg)
            rxc_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = rxc_pkg::ST_EXT_X;
                end
            end
            rxc_pkg::ST_EXT_X:
            begin
                mul_en     = 1'b1;
                mul_a      = AW'($signed({1'b0, scale_reg}));
                mul_b      = dx;
                clip_next  = rxc_pkg::CLIP_NONE;
                state_next = rxc_pkg::ST_EXT_Y;
            end
            rxc_pkg::ST_EXT_Y:
            begin
                ex_next    = ext_q[EW-1:0];
                mul_en     = 1'b1;
                mul_a      = AW'($signed({1'b0, scale_reg}));
                mul_b      = dy;
                state_next = rxc_pkg::ST_EXT_Z;
            end
            rxc_pkg::ST_EXT_Z:
            begin
                ey_next    = ext_q[EW-1:0];
                state_next = rxc_pkg::ST_EDGE;
            end
            rxc_pkg::ST_EDGE:
            begin
                // first violated edge in the order top, right, bottom, left
                state_next = rxc_pkg::ST_MUL_B;
                mul_en     = 1'b1;
                if (ey_reg < 0)
                begin
                    clip_next = rxc_pkg::CLIP_TOP;
                    mul_a     = AW'(ex_reg);
                    mul_b     = dy;
                    diff_next = AW'(0) - AW'(ey_reg);
                    ey_next   = '0;
                    if (dy == '0)
                    begin
                        state_next = rxc_pkg::ST_FIN;
                    end
                end
                else if (ex_reg > EDGE_R)
                begin
                    clip_next = rxc_pkg::CLIP_RIGHT;
                    mul_a     = AW'(ey_reg);
                    mul_b     = dx;
                    diff_next = AW'(EDGE_R) - AW'(ex_reg);
                    ex_next   = EDGE_R;
                    if (dx == '0)
                    begin
                        state_next = rxc_pkg::ST_FIN;
                    end
                end
                else if (ey_reg > EDGE_B)
                begin
                    clip_next = rxc_pkg::CLIP_BOTTOM;
                    mul_a     = AW'(ex_reg);
                    mul_b     = dy;
                    diff_next = AW'(EDGE_B) - AW'(ey_reg);
                    ey_next   = EDGE_B;
                    if (dy == '0)
                    begin
                        state_next = rxc_pkg::ST_FIN;
                    end
                end
                else if (ex_reg < 0)
                begin
                    clip_next = rxc_pkg::CLIP_LEFT;
                    mul_a     = AW'(ey_reg);
                    mul_b     = dx;
                    diff_next = AW'(0) - AW'(ex_reg);
                    ex_next   = '0;
                    if (dx == '0)
                    begin
                        state_next = rxc_pkg::ST_FIN;
                    end
                end
                else
                begin
                    mul_en     = 1'b0;
                    state_next = rxc_pkg::ST_FIN;
                end
            end
            rxc_pkg::ST_MUL_B:
            begin
                acc_next   = prod;
                mul_en     = 1'b1;
                mul_a      = diff_reg;
                mul_b      = vert_kept ? dx : dy;
                state_next = rxc_pkg::ST_SUM;
            end
            rxc_pkg::ST_SUM:
            begin
                num_next   = UW'(acc_reg) + UW'(prod);
                state_next = rxc_pkg::ST_DIV_GO;
            end
            rxc_pkg::ST_DIV_GO:
            begin
                div_start  = 1'b1;
                div_num    = num_abs[NW-1:0];
                div_den    = den_abs[DW-1:0];
                neg_next   = num_reg[UW-1] ^ den_s[DLW-1];
                state_next = rxc_pkg::ST_DIV_WAIT;
            end
            rxc_pkg::ST_DIV_WAIT:
            begin
                if (div_st.done)
                begin
                    if (vert_kept)
                    begin
                        ex_next = quo_sat;
                    end
                    else
                    begin
                        ey_next = quo_sat;
                    end
                    state_next = rxc_pkg::ST_FIN;
                end
            end
            rxc_pkg::ST_FIN:
            begin
                if (!ovalid_reg || !out_stall)
                begin
                    ovalid_next = 1'b1;
                    osx_next    = htx_reg;
                    osy_next    = hty_reg;
                    oex_next    = ex_reg;
                    oey_next    = ey_reg;
                    omode_next  = mode_reg;
                    state_next  = rxc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rxc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= rxc_pkg::ST_IDLE;
            mode_reg   <= rxc_pkg::MODE_OFF;
            scale_reg  <= '0;
            hbx_reg    <= '0;
            hby_reg    <= '0;
            htx_reg    <= '0;
            hty_reg    <= '0;
            clip_reg   <= rxc_pkg::CLIP_NONE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            mode_reg   <= mode_next;
            scale_reg  <= scale_next;
            hbx_reg    <= hbx_next;
            hby_reg    <= hby_next;
            htx_reg    <= htx_next;
            hty_reg    <= hty_next;
            clip_reg   <= clip_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ex_reg    <= ex_next;
        ey_reg    <= ey_next;
        diff_reg  <= diff_next;
        acc_reg   <= acc_next;
        num_reg   <= num_next;
        neg_reg   <= neg_next;
        osx_reg   <= osx_next;
        osy_reg   <= osy_next;
        oex_reg   <= oex_next;
        oey_reg   <= oey_next;
        omode_reg <= omode_next;
    end

    assign out_valid = ovalid_reg;
    assign start_x   = osx_reg;
    assign start_y   = osy_reg;
    assign end_x     = oex_reg;
    assign end_y     = oey_reg;
    assign ray_mode  = omode_reg;

    // ray off always means no extension
    assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == rxc_pkg::MODE_OFF) |-> (scale_reg == '0))
        else $error("ray off with nonzero scale");

    // the sequencer only waits on a divider that is running or finishing
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rxc_pkg::ST_DIV_WAIT) |-> (div_st.busy || div_st.done))
        else $error("waiting on an idle divider");

    // a finished item always lands in the output register
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rxc_pkg::ST_FIN && state_next == rxc_pkg::ST_IDLE) |=> out_valid)
        else $error("finished item not presented");

    // the divider is never restarted while it runs
    assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_st.busy)
        else $error("divider restarted while busy");

endmodule
